>>> sv/bmh_pkg.sv
`timescale 1ns / 1ps

package bmh_pkg;

   // Fixed field widths of the item and result channels.
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   // Value returned by a remove from an empty heap.
   localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Heap position that the memory read port looks at.
   typedef enum logic [2:0] {
      RD_NONE,
      RD_ROOT,
      RD_PARENT,
      RD_LAST,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   // Data written at the current position.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_RDATA,
      WR_VAL,
      WR_BEST
   } wr_sel_type;

   // Update of the current position.
   typedef enum logic [2:0] {
      POS_HOLD,
      POS_NEWCNT,
      POS_HALF,
      POS_ONE,
      POS_LEFT,
      POS_BEST
   } pos_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      pos_op_type pos_op;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       top_load;
      logic       val_from_rd;
      logic       child_load;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic has_left;
      logic has_right;
      logic parent_lt;
      logic left_gt;
      logic best_gt;
      logic cnt_zero;
   } stat_type;

endpackage

>>> sv/binary_max_heap_unit.sv
`timescale 1ns / 1ps

// Binary max-heap priority queue of up to CAPACITY signed 32-bit values. Each
// item is an insert (req_kind 0) or a remove-maximum (req_kind 1) and yields
// one result item with a status (ok, full, empty), the removed maximum (zero
// for inserts, 2147483647 for a remove from an empty heap) and the element
// count after the operation. One item is processed at a time; the single read
// port of the heap memory sets the pace. An insert moves the value up from the
// new last position and a remove moves the last element down from the root,
// at most floor(log2(CAPACITY)) levels either way. A finished result is handed
// to the output register once it is free, and waits there while the next item
// is already accepted.

module binary_max_heap_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic signed [bmh_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bmh_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [bmh_pkg::VALUE_W-1:0] rsp_max_value,
   output logic [bmh_pkg::COUNT_W-1:0]        rsp_count
);
   import bmh_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Operation sequencer.
   bmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Heap memory, count and compare logic.
   bmh_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_max_value (rsp_max_value),
      .rsp_count     (rsp_count)
   );

endmodule

>>> sv/bmh_datapath.sv
`timescale 1ns / 1ps

module bmh_datapath #(
   parameter int CAPACITY = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_kind,
   input  logic signed [bmh_pkg::VALUE_W-1:0]     req_value,
   input  bmh_pkg::cmd_type                       cmd,
   output bmh_pkg::stat_type                      stat,
   output logic [bmh_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [bmh_pkg::VALUE_W-1:0]     rsp_max_value,
   output logic [bmh_pkg::COUNT_W-1:0]            rsp_count
);
   import bmh_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   // Heap storage: position p lives in entry p-1.
   logic signed [VALUE_W-1:0] mem [CAPACITY];

   logic signed [VALUE_W-1:0] val_ff;
   logic signed [VALUE_W-1:0] top_ff;
   logic signed [VALUE_W-1:0] child_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      kind_ff;
   logic [CW-1:0]             pos_ff;
   logic [CW-1:0]             pos_in;
   logic [CW-1:0]             cnt_ff;
   logic [CW-1:0]             cnt_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_max_value_ff;
   logic signed [VALUE_W-1:0] max_in;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic [CW:0]               left_pos;
   logic [CW:0]               right_pos;
   logic [CW:0]               rd_pos;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;
   logic                      rd_en;
   logic                      wr_en;
   logic signed [VALUE_W-1:0] wr_data;
   logic                      right_gt;
   logic signed [VALUE_W-1:0] best_val;

   // Child positions of the current position.
   assign left_pos  = {pos_ff, 1'b0};
   assign right_pos = {pos_ff, 1'b1};

   // The larger child, left winning a tie.
   assign right_gt = rd_data_ff > child_ff;
   assign best_val = right_gt ? rd_data_ff : child_ff;

   // Read address selection.
   always_comb begin
      case (cmd.rd_sel)
         RD_ROOT:   rd_pos = (CW+1)'(1);
         RD_PARENT: rd_pos = {1'b0, pos_ff >> 1};
         RD_LAST:   rd_pos = {1'b0, cnt_ff};
         RD_LEFT:   rd_pos = left_pos;
         RD_RIGHT:  rd_pos = right_pos;
         default:   rd_pos = (CW+1)'(1);
      endcase
   end

   assign rd_en   = cmd.rd_sel != RD_NONE;
   assign rd_addr = AW'(rd_pos - (CW+1)'(1));
   assign wr_addr = AW'(pos_ff - CW'(1));

   // Write data selection.
   always_comb begin
      case (cmd.wr_sel)
         WR_RDATA: wr_data = rd_data_ff;
         WR_VAL:   wr_data = val_ff;
         WR_BEST:  wr_data = best_val;
         default:  wr_data = val_ff;
      endcase
   end

   assign wr_en = cmd.wr_sel != WR_NONE;

   // Memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next position.
   always_comb begin
      case (cmd.pos_op)
         POS_NEWCNT: pos_in = cnt_ff + CW'(1);
         POS_HALF:   pos_in = pos_ff >> 1;
         POS_ONE:    pos_in = CW'(1);
         POS_LEFT:   pos_in = left_pos[CW-1:0];
         POS_BEST:   pos_in = right_gt ? right_pos[CW-1:0] : left_pos[CW-1:0];
         default:    pos_in = pos_ff;
      endcase
   end

   // Next element count.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // Removed maximum, or the fixed value for the other outcomes.
   always_comb begin
      case (cmd.rsp_status)
         ST_EMPTY: max_in = MAX_VALUE;
         ST_FULL:  max_in = '0;
         default:  max_in = kind_ff ? top_ff : '0;
      endcase
   end

   // Element count is the only datapath register that needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load_req) begin
         val_ff  <= req_value;
         kind_ff <= req_kind;
      end else if (cmd.val_from_rd) begin
         val_ff <= rd_data_ff;
      end
      if (cmd.top_load) begin
         top_ff <= rd_data_ff;
      end
      if (cmd.child_load) begin
         child_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff    <= cmd.rsp_status;
         rsp_max_value_ff <= max_in;
         rsp_count_ff     <= COUNT_W'(cnt_ff);
      end
   end

   // Status back to the controller.
   assign stat.full      = cnt_ff == CW'(CAPACITY);
   assign stat.empty     = cnt_ff == '0;
   assign stat.at_root   = pos_ff == CW'(1);
   assign stat.has_left  = left_pos <= {1'b0, cnt_ff};
   assign stat.has_right = right_pos <= {1'b0, cnt_ff};
   assign stat.parent_lt = rd_data_ff < val_ff;
   assign stat.left_gt   = val_ff < rd_data_ff;
   assign stat.best_gt   = val_ff < best_val;
   assign stat.cnt_zero  = cnt_ff == '0;

   assign rsp_status    = rsp_status_ff;
   assign rsp_max_value = rsp_max_value_ff;
   assign rsp_count     = rsp_count_ff;

endmodule

>>> sv/bmh_ctrl.sv
`timescale 1ns / 1ps

module bmh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_kind,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  bmh_pkg::stat_type  stat,
   output bmh_pkg::cmd_type   cmd
);
   import bmh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHK,
      S_UP_CMP,
      S_RM_TOP,
      S_RM_LAST,
      S_DN_CHK,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_END,
      S_DONE
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   status_type status_ff;
   status_type status_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // An item is taken only while no operation is in progress.
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Sequencing of the sift-up and sift-down walks.
   always_comb begin
      cmd.load_req    = 1'b0;
      cmd.rd_sel      = RD_NONE;
      cmd.wr_sel      = WR_NONE;
      cmd.pos_op      = POS_HOLD;
      cmd.cnt_inc     = 1'b0;
      cmd.cnt_dec     = 1'b0;
      cmd.top_load    = 1'b0;
      cmd.val_from_rd = 1'b0;
      cmd.child_load  = 1'b0;
      cmd.rsp_load    = 1'b0;
      cmd.rsp_status  = status_ff;
      state_in        = state_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (!req_kind) begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     status_in   = ST_OK;
                     cmd.cnt_inc = 1'b1;
                     cmd.pos_op  = POS_NEWCNT;
                     state_in    = S_UP_CHK;
                  end
               end else begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     status_in  = ST_OK;
                     cmd.rd_sel = RD_ROOT;
                     state_in   = S_RM_TOP;
                  end
               end
            end
         end
         // Insert: fetch the parent unless the root is reached.
         S_UP_CHK: begin
            if (stat.at_root) begin
               cmd.wr_sel = WR_VAL;
               state_in   = S_DONE;
            end else begin
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         // Insert: a smaller parent moves down, otherwise the value settles.
         S_UP_CMP: begin
            if (stat.parent_lt) begin
               cmd.wr_sel = WR_RDATA;
               cmd.pos_op = POS_HALF;
               state_in   = S_UP_CHK;
            end else begin
               cmd.wr_sel = WR_VAL;
               state_in   = S_DONE;
            end
         end
         // Remove: keep the root and fetch the last element.
         S_RM_TOP: begin
            cmd.top_load = 1'b1;
            cmd.rd_sel   = RD_LAST;
            state_in     = S_RM_LAST;
         end
         S_RM_LAST: begin
            cmd.val_from_rd = 1'b1;
            cmd.cnt_dec     = 1'b1;
            cmd.pos_op      = POS_ONE;
            state_in        = S_DN_CHK;
         end
         // Remove: fetch the left child if there is one.
         S_DN_CHK: begin
            if (stat.has_left) begin
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_LEFT;
            end else begin
               state_in = S_DN_END;
            end
         end
         // Remove: with a single child, compare at once.
         S_DN_LEFT: begin
            if (stat.has_right) begin
               cmd.child_load = 1'b1;
               cmd.rd_sel     = RD_RIGHT;
               state_in       = S_DN_RIGHT;
            end else if (stat.left_gt) begin
               cmd.wr_sel = WR_RDATA;
               cmd.pos_op = POS_LEFT;
               state_in   = S_DN_CHK;
            end else begin
               state_in = S_DN_END;
            end
         end
         // Remove: the larger child moves up if it beats the last element.
         S_DN_RIGHT: begin
            if (stat.best_gt) begin
               cmd.wr_sel = WR_BEST;
               cmd.pos_op = POS_BEST;
               state_in   = S_DN_CHK;
            end else begin
               state_in = S_DN_END;
            end
         end
         S_DN_END: begin
            if (!stat.cnt_zero) begin
               cmd.wr_sel = WR_VAL;
            end
            state_in = S_DONE;
         end
         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bmh_pkg::*;

   localparam int CAPACITY    = 1024;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 60;

   // Operation codes carried by req_kind.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
   } heap_op_type;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] max_value;
      logic [COUNT_W-1:0]        count;
   } heap_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_kind = OP_INSERT;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_max_value;
   logic [COUNT_W-1:0]        rsp_count;

   binary_max_heap_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_max_value(rsp_max_value),
      .rsp_count    (rsp_count)
   );

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   heap_op_type     op_backlog[$];
   heap_result_type awaited_results[$];
   idle_mode_type   idle_mode = IDLE_NONE;
   int              issued_total = 0;
   int              answered_total = 0;
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   int              gen_count = 0;
   logic            req_taken = 1'b0;

   // Mirror of the heap contents, kept 1-based: position p lives in entry p-1.
   logic signed [VALUE_W-1:0] heap_mirror[CAPACITY];
   int                        mirror_count = 0;

   function automatic bit chance(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Applies one operation to the mirror and returns the result it must produce.
   function automatic heap_result_type apply_heap_op(logic kind, logic signed [VALUE_W-1:0] v);
      heap_result_type           r;
      int                        pos;
      int                        parent;
      int                        left;
      int                        best;
      int                        n;
      bit                        sinking;
      logic signed [VALUE_W-1:0] top;
      logic signed [VALUE_W-1:0] last;
      r.status    = ST_OK;
      r.max_value = '0;
      if (kind == OP_INSERT) begin
         if (mirror_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            // Sift up; the climb stops at the root by position, not by a sentinel.
            mirror_count++;
            pos = mirror_count;
            while (pos > 1 && heap_mirror[pos/2 - 1] < v) begin
               heap_mirror[pos-1] = heap_mirror[pos/2 - 1];
               pos = pos / 2;
            end
            heap_mirror[pos-1] = v;
         end
      end else if (mirror_count == 0) begin
         r.status    = ST_EMPTY;
         r.max_value = MAX_VALUE;
      end else begin
         // Take the root, then sink the last element; ties go to the left child.
         top  = heap_mirror[0];
         last = heap_mirror[mirror_count-1];
         mirror_count--;
         n       = mirror_count;
         parent  = 1;
         sinking = 1'b1;
         while (sinking && 2 * parent <= n) begin
            left = 2 * parent;
            best = left;
            if (left + 1 <= n && heap_mirror[left] > heap_mirror[left-1])
               best = left + 1;
            if (last < heap_mirror[best-1]) begin
               heap_mirror[parent-1] = heap_mirror[best-1];
               parent = best;
            end else begin
               sinking = 1'b0;
            end
         end
         if (n > 0)
            heap_mirror[parent-1] = last;
         r.max_value = top;
      end
      r.count = mirror_count[COUNT_W-1:0];
      return r;
   endfunction

   // Values lean toward the extremes and a narrow band, so duplicates occur.
   function automatic logic signed [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Queues one item and tracks the count that the heap will hold after it.
   task automatic queue_op(logic kind, logic signed [VALUE_W-1:0] v);
      heap_op_type op;
      op.kind  = kind;
      op.value = v;
      op_backlog.push_back(op);
      issued_total++;
      if (kind == OP_INSERT && gen_count < CAPACITY)
         gen_count++;
      else if (kind == OP_REMOVE && gen_count > 0)
         gen_count--;
   endtask

   task automatic queue_mixed(int count, int insert_pct);
      for (int i = 0; i < count; i++) begin
         queue_op(chance(insert_pct) ? OP_INSERT : OP_REMOVE, rand_value());
      end
   endtask

   task automatic drain_wait();
      while (answered_total < issued_total) @(posedge clock);
   endtask

   // Driver: presents the next item on the falling edge and holds it until taken.
   always @(negedge clock) begin : drive_proc
      heap_op_type next_op;
      bit          sender_idle;
      if (!reset) begin
         sender_idle = (idle_mode == IDLE_SENDER) ? chance(72) :
                       (idle_mode == IDLE_BOTH)   ? chance(20) : 1'b0;
         if (!req_valid || req_taken) begin
            if (op_backlog.size() > 0 && !sender_idle) begin
               next_op = op_backlog.pop_front();
               req_valid <= 1'b1;
               req_kind  <= next_op.kind;
               req_value <= next_op.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= (idle_mode == IDLE_RECEIVER) ? chance(72) :
                      (idle_mode == IDLE_BOTH)     ? chance(20) : 1'b0;
      end
   end

   // Monitor: checks results, predicts accepted items and watches for a hang.
   always @(posedge clock) begin : monitor_proc
      heap_result_type want;
      bit              moved;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            answered_total <= answered_total + 1;
            if (awaited_results.size() == 0) begin
               $display("%0t: result item with none expected: status %0d max %0d count %0d",
                        $time, rsp_status, rsp_max_value, rsp_count);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_max_value !== want.max_value) begin
                  $display("%0t: max_value mismatch, expected %0d, actual %0d",
                           $time, want.max_value, rsp_max_value);
                  mismatch_count++;
               end
               if (rsp_count !== want.count) begin
                  $display("%0t: count mismatch, expected %0d, actual %0d",
                           $time, want.count, rsp_count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            awaited_results.push_back(apply_heap_op(req_kind, req_value));
         end
         req_taken    <= req_valid && !req_stall;
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Stimulus: directed corners, then a fill to capacity, then remove-heavy and balanced phases.
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Remove from an empty heap, with extreme payloads on the ignored value.
      idle_mode = IDLE_NONE;
      queue_op(OP_REMOVE, 32'sh7FFF_FFFF);
      queue_op(OP_REMOVE, 32'sh8000_0000);
      // The largest value must climb all the way to the root.
      queue_op(OP_INSERT, 32'sh8000_0000);
      queue_op(OP_INSERT, 32'sh0000_0000);
      queue_op(OP_INSERT, 32'sh7FFF_FFFF);
      queue_op(OP_INSERT, -32'sd1);
      queue_op(OP_INSERT, 32'sh7FFF_FFFF);
      queue_op(OP_INSERT, 32'sd5);
      queue_op(OP_INSERT, 32'sd5);
      queue_op(OP_INSERT, 32'sd5);
      queue_op(OP_INSERT, 32'sh8000_0000);
      queue_op(OP_INSERT, 32'sd1);
      // Drain completely, including equal children, then one more from empty.
      for (int i = 0; i < 11; i++) queue_op(OP_REMOVE, rand_value());
      queue_mixed(100, 55);
      drain_wait();

      // Fill to capacity, then probe the full heap.
      idle_mode = IDLE_SENDER;
      while (gen_count < CAPACITY) begin
         queue_op((gen_count == 0 || chance(95)) ? OP_INSERT : OP_REMOVE, rand_value());
      end
      for (int i = 0; i < 12; i++) begin
         if (i % 4 == 3) begin
            queue_op(OP_REMOVE, rand_value());
            queue_op(OP_INSERT, rand_value());
         end else begin
            queue_op(OP_INSERT, rand_value());
         end
      end
      drain_wait();

      // Mostly removes from a deep heap under receiver back-pressure.
      idle_mode = IDLE_RECEIVER;
      queue_mixed(200, 15);
      drain_wait();

      idle_mode = IDLE_BOTH;
      queue_mixed(100, 50);
      drain_wait();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> binary_max_heap_unit.f
sv/bmh_pkg.sv
sv/bmh_datapath.sv
sv/bmh_ctrl.sv
sv/binary_max_heap_unit.sv
test/tb_top.sv
